// ----- rtl/core/iotws_pkg.sv -----
// Package for the I/O trace write-size statistics block.
// Holds sizes, character codes, status codes and the line record type.
// Used by every module in rtl/core; depends on nothing.
package iotws_pkg;

    // Sizing of the block
    localparam int SIZE_BITS  = 24;
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // Fixed widths of the running sums
    localparam int SUM_BITS = 56;
    localparam int SQ_BITS  = 64;

    // Result field widths
    localparam int RATIO_BITS = 17;
    localparam int STAT_BITS  = 31;
    localparam int OUT_COUNT_BITS = 32;
    localparam logic [STAT_BITS-1:0] OUT_CAP = STAT_BITS'(1 << 30);

    // Character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] SEP_RESET    = 8'h2c;

    // Field bookkeeping
    localparam logic [2:0] FIELD_LAST  = 3'd7;
    localparam logic [2:0] TYPE_FIELD  = 3'd3;
    localparam logic [2:0] SIZE_FIELD  = 3'd5;
    localparam logic [2:0] READ_LEN    = 3'd4;
    localparam logic [2:0] WRITE_LEN   = 3'd5;
    localparam logic [2:0] TYPE_CHARS_MAX = 3'd7;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_WRITES = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    // Line queue between front and back
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    // Wide arithmetic: shifts that scale the mean and variance to Q format
    localparam int MSH  = (FRAC_BITS >= 10) ? FRAC_BITS - 10 : 0;
    localparam int MDSH = (FRAC_BITS >= 10) ? 0 : 10 - FRAC_BITS;
    localparam int NSH  = (2 * FRAC_BITS >= 20) ? 2 * FRAC_BITS - 20 : 0;
    localparam int DSH  = (2 * FRAC_BITS >= 20) ? 0 : 20 - 2 * FRAC_BITS;

    // Products up to 2*S^2*W, plus headroom
    localparam int PROD_BITS  = 2 * SUM_BITS + COUNT_BITS + 2;
    localparam int MUL_Y_BITS = SQ_BITS;
    localparam int DIVN_BITS  = PROD_BITS + NSH;
    localparam int DIVD_BITS  = 3 * COUNT_BITS + DSH;
    localparam int DIV_CNT_BITS = $clog2(DIVN_BITS);

    // Square root unit
    localparam int SQRT_IN_BITS  = 62;
    localparam int SQRT_OUT_BITS = 31;
    localparam int SQRT_REM_BITS = 34;
    localparam logic [4:0] SQRT_LAST_STEP = 5'(SQRT_OUT_BITS - 1);

    // One closed line, or the end-of-trace marker
    typedef struct packed {
        logic                 last;
        logic                 close;
        logic                 is_read;
        logic                 is_write;
        logic                 sat;
        logic [SIZE_BITS-1:0] size;
    } rec_t;

    // Expected letter of "Read" at a position
    function automatic logic [7:0] read_letter(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0: ch = 8'h52;
            2'd1: ch = 8'h65;
            2'd2: ch = 8'h61;
            2'd3: ch = 8'h64;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected letter of "Write" at a position
    function automatic logic [7:0] write_letter(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0: ch = 8'h57;
            3'd1: ch = 8'h72;
            3'd2: ch = 8'h69;
            3'd3: ch = 8'h74;
            3'd4: ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/iotws_fifo.sv -----
// Short line-record queue between the parser front end and the back end.
// Depends on iotws_pkg for rec_t and the queue depth.
module iotws_fifo import iotws_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t pop_rec,
    output logic empty
);

    rec_t                   mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg;
    logic                     do_push, do_pop;

    assign full    = (count_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

endmodule

// ----- rtl/core/iotws_front.sv -----
// Front end: parses trace characters into closed-line records.
// Holds the separator register; depends on iotws_pkg.
module iotws_front import iotws_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       cmd,
    input  logic [7:0] char_byte,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    logic [7:0]           sep_reg;
    logic [2:0]           field_reg, field_next;
    logic [2:0]           tc_reg, tc_next;
    logic                 cbr_reg, cbr_next;
    logic                 cbw_reg, cbw_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic                 open_reg, open_next;
    logic                 lsat_reg, lsat_next;

    logic                   accept, is_nl, spoil;
    logic [SIZE_BITS+3:0]   acc_wide;
    logic [7:0]             digit;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign is_nl  = (char_byte == CHAR_NEWLINE);
    assign spoil  = !cmd && is_nl && (field_reg == TYPE_FIELD);
    assign digit  = char_byte - CHAR_ZERO;
    assign acc_wide = ((SIZE_BITS+4)'(acc_reg) << 3) + ((SIZE_BITS+4)'(acc_reg) << 1)
                      + (SIZE_BITS+4)'(digit[3:0]);

    // Classify the character and build the line record
    always_comb
    begin
        field_next = field_reg;
        tc_next    = tc_reg;
        cbr_next   = cbr_reg;
        cbw_next   = cbw_reg;
        acc_next   = acc_reg;
        open_next  = open_reg;
        lsat_next  = lsat_reg;
        q_push     = 1'b0;

        q_rec.last     = cmd;
        q_rec.close    = cmd ? open_reg : 1'b1;
        q_rec.is_read  = cbr_reg && !spoil && (tc_reg == READ_LEN);
        q_rec.is_write = cbw_reg && !spoil && (tc_reg == WRITE_LEN);
        q_rec.sat      = lsat_reg;
        q_rec.size     = acc_reg;

        if (accept)
        begin
            if (cmd || is_nl)
            begin
                // close the line and clear line state
                q_push     = 1'b1;
                field_next = '0;
                tc_next    = '0;
                cbr_next   = 1'b1;
                cbw_next   = 1'b1;
                acc_next   = '0;
                open_next  = 1'b0;
                lsat_next  = 1'b0;
            end
            else
            begin
                open_next = 1'b1;
                priority if (char_byte == sep_reg)
                begin
                    if (field_reg != FIELD_LAST)
                        field_next = field_reg + 1'b1;
                end
                else if (field_reg == TYPE_FIELD)
                begin
                    if (tc_reg >= READ_LEN || char_byte != read_letter(tc_reg[1:0]))
                        cbr_next = 1'b0;
                    if (tc_reg >= WRITE_LEN || char_byte != write_letter(tc_reg))
                        cbw_next = 1'b0;
                    if (tc_reg != TYPE_CHARS_MAX)
                        tc_next = tc_reg + 1'b1;
                end
                else if (field_reg == SIZE_FIELD && char_byte >= CHAR_ZERO
                         && char_byte <= CHAR_NINE)
                begin
                    // accumulate a decimal digit, hold at full scale
                    if (|acc_wide[SIZE_BITS+3:SIZE_BITS])
                    begin
                        acc_next  = '1;
                        lsat_next = 1'b1;
                    end
                    else
                        acc_next = acc_wide[SIZE_BITS-1:0];
                end
            end
        end
    end

    // Line state and separator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= SEP_RESET;
            field_reg <= '0;
            tc_reg    <= '0;
            cbr_reg   <= 1'b1;
            cbw_reg   <= 1'b1;
            acc_reg   <= '0;
            open_reg  <= 1'b0;
            lsat_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                sep_reg <= cfg_wdata;
            field_reg <= field_next;
            tc_reg    <= tc_next;
            cbr_reg   <= cbr_next;
            cbw_reg   <= cbw_next;
            acc_reg   <= acc_next;
            open_reg  <= open_next;
            lsat_reg  <= lsat_next;
        end
    end

endmodule

// ----- rtl/core/iotws_mul.sv -----
// Shift-and-add multiplier, one bit of the multiplier operand per cycle.
// Stops early once the remaining operand bits are zero; depends on iotws_pkg.
module iotws_mul import iotws_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_BITS-1:0]  x,
    input  logic [MUL_Y_BITS-1:0] y,
    output logic [PROD_BITS-1:0]  p,
    output logic                  done
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [PROD_BITS-1:0]  x_reg;
    logic [MUL_Y_BITS-1:0] y_reg;
    logic [PROD_BITS-1:0]  p_reg;

    assign p    = p_reg;
    assign done = done_reg;

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && y_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Add the shifted multiplicand for each set bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            p_reg <= '0;
        end
        else if (busy_reg && y_reg != '0)
        begin
            if (y_reg[0])
                p_reg <= p_reg + x_reg;
            x_reg <= x_reg << 1;
            y_reg <= y_reg >> 1;
        end
    end

endmodule

// ----- rtl/core/iotws_div.sv -----
// Restoring divider, one quotient bit per cycle over a DIVN_BITS-bit dividend.
// Depends on iotws_pkg for operand widths.
module iotws_div import iotws_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIVN_BITS-1:0] n,
    input  logic [DIVD_BITS-1:0] d,
    output logic [DIVN_BITS-1:0] q,
    output logic                 done
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIVN_BITS-1:0]    nq_reg;
    logic [DIVD_BITS-1:0]    rem_reg;
    logic [DIVD_BITS-1:0]    d_reg;

    logic [DIVD_BITS:0] trial, diff;
    logic               ge;

    assign trial = {rem_reg, nq_reg[DIVN_BITS-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});
    assign q     = nq_reg;
    assign done  = done_reg;

    // Count quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIVN_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in a dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIVD_BITS-1:0] : trial[DIVD_BITS-1:0];
            nq_reg  <= {nq_reg[DIVN_BITS-2:0], ge};
        end
    end

endmodule

// ----- rtl/core/iotws_back.sv -----
// Back end: accumulates closed lines and computes the end-of-trace result.
// Uses iotws_mul and iotws_div; holds the result register. Depends on iotws_pkg.
module iotws_back import iotws_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  rec_t                      q_rec,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [OUT_COUNT_BITS-1:0] reads_seen,
    output logic [OUT_COUNT_BITS-1:0] writes_seen,
    output logic [RATIO_BITS-1:0]     write_ratio_q16,
    output logic [STAT_BITS-1:0]      mean_kib_q16,
    output logic [STAT_BITS-1:0]      deviation_kib_q16,
    output logic [1:0]                status
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQUARE = 4'd1;
    localparam logic [3:0] ST_ACCUM  = 4'd2;
    localparam logic [3:0] ST_RATIO  = 4'd3;
    localparam logic [3:0] ST_MEAN   = 4'd4;
    localparam logic [3:0] ST_SS     = 4'd5;
    localparam logic [3:0] ST_QW     = 4'd6;
    localparam logic [3:0] ST_QWW    = 4'd7;
    localparam logic [3:0] ST_SSW    = 4'd8;
    localparam logic [3:0] ST_SSN    = 4'd9;
    localparam logic [3:0] ST_WW     = 4'd10;
    localparam logic [3:0] ST_WWW    = 4'd11;
    localparam logic [3:0] ST_NUM    = 4'd12;
    localparam logic [3:0] ST_VAR    = 4'd13;
    localparam logic [3:0] ST_ROOT   = 4'd14;
    localparam logic [3:0] ST_LOAD   = 4'd15;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Control and totals
    logic [3:0]            state_reg, state_next;
    logic                  iss_reg, iss_next;
    logic [COUNT_BITS-1:0] read_reg, read_next;
    logic [COUNT_BITS-1:0] write_reg, write_next;
    logic [COUNT_BITS-1:0] nonread_reg, nonread_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;

    // Working registers
    rec_t                      rec_reg, rec_next;
    logic [2*SIZE_BITS-1:0]    prod_reg, prod_next;
    logic [PROD_BITS-1:0]      a_reg, a_next;
    logic [PROD_BITS-1:0]      b_reg, b_next;
    logic [PROD_BITS-1:0]      c_reg, c_next;
    logic [PROD_BITS-1:0]      d_reg, d_next;
    logic [PROD_BITS-1:0]      s2_reg, s2_next;
    logic [RATIO_BITS-1:0]     ratio_reg, ratio_next;
    logic [STAT_BITS-1:0]      mean_reg, mean_next;
    logic [STAT_BITS-1:0]      dev_reg, dev_next;
    logic [SQRT_IN_BITS-1:0]   sx_reg, sx_next;
    logic [SQRT_REM_BITS-1:0]  srem_reg, srem_next;
    logic [SQRT_OUT_BITS-1:0]  sroot_reg, sroot_next;
    logic [4:0]                scnt_reg, scnt_next;

    // Result register
    logic [OUT_COUNT_BITS-1:0] out_reads_reg, out_reads_next;
    logic [OUT_COUNT_BITS-1:0] out_writes_reg, out_writes_next;
    logic [RATIO_BITS-1:0]     out_ratio_reg, out_ratio_next;
    logic [STAT_BITS-1:0]      out_mean_reg, out_mean_next;
    logic [STAT_BITS-1:0]      out_dev_reg, out_dev_next;
    logic [1:0]                out_status_reg, out_status_next;

    // Arithmetic units
    logic                  mul_start, mul_done;
    logic [PROD_BITS-1:0]  mul_x, mul_p;
    logic [MUL_Y_BITS-1:0] mul_y;
    logic                  div_start, div_done;
    logic [DIVN_BITS-1:0]  div_n, div_q;
    logic [DIVD_BITS-1:0]  div_d;

    logic                    mul_state, div_state, pop_out;
    logic [COUNT_BITS:0]     tot;
    logic [SUM_BITS:0]       sum_wide;
    logic [SQ_BITS:0]        sq_wide;
    logic [PROD_BITS-1:0]    ab_sum;
    logic [SQRT_REM_BITS+1:0] root_rem, root_trial;
    logic                    root_ge;
    logic [SQRT_OUT_BITS-1:0] root_new;

    iotws_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .p     (mul_p),
        .done  (mul_done)
    );

    iotws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .q     (div_q),
        .done  (div_done)
    );

    assign empty             = !out_valid_reg;
    assign pop_out           = pop && out_valid_reg;
    assign reads_seen        = out_reads_reg;
    assign writes_seen       = out_writes_reg;
    assign write_ratio_q16   = out_ratio_reg;
    assign mean_kib_q16      = out_mean_reg;
    assign deviation_kib_q16 = out_dev_reg;
    assign status            = out_status_reg;

    assign tot      = {1'b0, read_reg} + {1'b0, write_reg};
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(rec_reg.size);
    assign sq_wide  = {1'b0, sq_reg} + (SQ_BITS+1)'(prod_reg);
    assign ab_sum   = a_reg + b_reg;

    // One square-root digit: bring down two bits, try root*4+1
    assign root_rem   = {srem_reg, sx_reg[SQRT_IN_BITS-1:SQRT_IN_BITS-2]};
    assign root_trial = (SQRT_REM_BITS+2)'({sroot_reg, 2'b01});
    assign root_ge    = (root_rem >= root_trial);
    assign root_new   = {sroot_reg[SQRT_OUT_BITS-2:0], root_ge};

    assign mul_state = (state_reg == ST_SS) || (state_reg == ST_QW) || (state_reg == ST_QWW)
                       || (state_reg == ST_SSW) || (state_reg == ST_SSN)
                       || (state_reg == ST_WW) || (state_reg == ST_WWW);
    assign div_state = (state_reg == ST_RATIO && tot != '0) || (state_reg == ST_MEAN)
                       || (state_reg == ST_VAR);
    assign mul_start = mul_state && !iss_reg;
    assign div_start = div_state && !iss_reg;

    // Select unit operands by step
    always_comb
    begin
        mul_x = PROD_BITS'(write_reg);
        mul_y = MUL_Y_BITS'(write_reg);
        div_n = DIVN_BITS'(a_reg) << NSH;
        div_d = DIVD_BITS'(d_reg) << DSH;
        unique case (state_reg)
            ST_SS:
            begin
                mul_x = PROD_BITS'(sum_reg);
                mul_y = MUL_Y_BITS'(sum_reg);
            end
            ST_QW:  mul_x = PROD_BITS'(sq_reg);
            ST_QWW: mul_x = a_reg;
            ST_SSW: mul_x = s2_reg;
            ST_SSN:
            begin
                mul_x = s2_reg;
                mul_y = MUL_Y_BITS'(nonread_reg);
            end
            ST_WWW: mul_x = d_reg;
            ST_RATIO:
            begin
                div_n = DIVN_BITS'(write_reg) << FRAC_BITS;
                div_d = DIVD_BITS'(tot);
            end
            ST_MEAN:
            begin
                div_n = DIVN_BITS'(sum_reg) << MSH;
                div_d = DIVD_BITS'(write_reg) << MDSH;
            end
            default:
            begin
            end
        endcase
    end

    // Sequence line updates and the final computation
    always_comb
    begin
        state_next   = state_reg;
        iss_next     = iss_reg;
        read_next    = read_reg;
        write_next   = write_reg;
        nonread_next = nonread_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        sat_next     = sat_reg;
        rec_next     = rec_reg;
        prod_next    = prod_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        s2_next      = s2_reg;
        ratio_next   = ratio_reg;
        mean_next    = mean_reg;
        dev_next     = dev_reg;
        sx_next      = sx_reg;
        srem_next    = srem_reg;
        sroot_next   = sroot_reg;
        scnt_next    = scnt_reg;
        q_pop        = 1'b0;

        out_valid_next  = pop_out ? 1'b0 : out_valid_reg;
        out_reads_next  = out_reads_reg;
        out_writes_next = out_writes_reg;
        out_ratio_next  = out_ratio_reg;
        out_mean_next   = out_mean_reg;
        out_dev_next    = out_dev_reg;
        out_status_next = out_status_reg;

        if (mul_start || div_start)
            iss_next = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    rec_next   = q_rec;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                prod_next  = rec_reg.size * rec_reg.size;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (rec_reg.close)
                begin
                    if (rec_reg.sat)
                        sat_next = 1'b1;
                    if (rec_reg.is_read)
                    begin
                        if (read_reg == COUNT_MAX)
                            sat_next = 1'b1;
                        else
                            read_next = read_reg + 1'b1;
                    end
                    else
                    begin
                        if (nonread_reg == COUNT_MAX)
                            sat_next = 1'b1;
                        else
                            nonread_next = nonread_reg + 1'b1;
                        if (sum_wide[SUM_BITS])
                        begin
                            sum_next = '1;
                            sat_next = 1'b1;
                        end
                        else
                            sum_next = sum_wide[SUM_BITS-1:0];
                        if (sq_wide[SQ_BITS])
                        begin
                            sq_next  = '1;
                            sat_next = 1'b1;
                        end
                        else
                            sq_next = sq_wide[SQ_BITS-1:0];
                        if (rec_reg.is_write)
                        begin
                            if (write_reg == COUNT_MAX)
                                sat_next = 1'b1;
                            else
                                write_next = write_reg + 1'b1;
                        end
                    end
                end
                state_next = rec_reg.last ? ST_RATIO : ST_IDLE;
            end
            ST_RATIO:
            begin
                if (tot == '0)
                begin
                    ratio_next = '0;
                    state_next = (write_reg == '0) ? ST_LOAD : ST_MEAN;
                end
                else if (div_done)
                begin
                    iss_next   = 1'b0;
                    ratio_next = div_q[RATIO_BITS-1:0];
                    state_next = (write_reg == '0) ? ST_LOAD : ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    iss_next = 1'b0;
                    if (div_q > DIVN_BITS'(OUT_CAP))
                    begin
                        mean_next = OUT_CAP;
                        sat_next  = 1'b1;
                    end
                    else
                        mean_next = div_q[STAT_BITS-1:0];
                    state_next = ST_SS;
                end
            end
            ST_SS, ST_QW, ST_QWW, ST_SSW, ST_SSN, ST_WW, ST_WWW:
            begin
                if (mul_done)
                begin
                    iss_next = 1'b0;
                    unique case (state_reg)
                        ST_SS:
                        begin
                            s2_next    = mul_p;
                            state_next = ST_QW;
                        end
                        ST_QW:
                        begin
                            a_next     = mul_p;
                            state_next = ST_QWW;
                        end
                        ST_QWW:
                        begin
                            a_next     = mul_p;
                            state_next = ST_SSW;
                        end
                        ST_SSW:
                        begin
                            c_next     = mul_p << 1;
                            state_next = ST_SSN;
                        end
                        ST_SSN:
                        begin
                            b_next     = mul_p;
                            state_next = ST_WW;
                        end
                        ST_WW:
                        begin
                            d_next     = mul_p;
                            state_next = ST_WWW;
                        end
                        default:
                        begin
                            d_next     = mul_p;
                            state_next = ST_NUM;
                        end
                    endcase
                end
            end
            ST_NUM:
            begin
                // clamp a negative variance numerator at zero
                if (ab_sum < c_reg)
                begin
                    a_next   = '0;
                    sat_next = 1'b1;
                end
                else
                    a_next = ab_sum - c_reg;
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                if (div_done)
                begin
                    iss_next = 1'b0;
                    if (|div_q[DIVN_BITS-1:SQRT_IN_BITS])
                    begin
                        dev_next   = OUT_CAP;
                        sat_next   = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        sx_next    = div_q[SQRT_IN_BITS-1:0];
                        srem_next  = '0;
                        sroot_next = '0;
                        scnt_next  = SQRT_LAST_STEP;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                sx_next    = sx_reg << 2;
                srem_next  = root_ge ? SQRT_REM_BITS'(root_rem - root_trial)
                                     : SQRT_REM_BITS'(root_rem);
                sroot_next = root_new;
                scnt_next  = scnt_reg - 1'b1;
                if (scnt_reg == '0)
                begin
                    if (root_new > OUT_CAP)
                    begin
                        dev_next = OUT_CAP;
                        sat_next = 1'b1;
                    end
                    else
                        dev_next = root_new;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // wait for the result register, then clear the totals
                if (!out_valid_reg || pop_out)
                begin
                    out_valid_next  = 1'b1;
                    out_reads_next  = OUT_COUNT_BITS'(read_reg);
                    out_writes_next = OUT_COUNT_BITS'(write_reg);
                    out_ratio_next  = ratio_reg;
                    if (write_reg == '0)
                    begin
                        out_mean_next   = '0;
                        out_dev_next    = '0;
                        out_status_next = STATUS_NO_WRITES;
                    end
                    else
                    begin
                        out_mean_next   = mean_reg;
                        out_dev_next    = dev_reg;
                        out_status_next = sat_reg ? STATUS_SATURATED : STATUS_OK;
                    end
                    read_next    = '0;
                    write_next   = '0;
                    nonread_next = '0;
                    sum_next     = '0;
                    sq_next      = '0;
                    sat_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= 1'b0;
            read_reg      <= '0;
            write_reg     <= '0;
            nonread_reg   <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            read_reg      <= read_next;
            write_reg     <= write_next;
            nonread_reg   <= nonread_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values and result payload
    always_ff @(posedge clk)
    begin
        rec_reg        <= rec_next;
        prod_reg       <= prod_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        s2_reg         <= s2_next;
        ratio_reg      <= ratio_next;
        mean_reg       <= mean_next;
        dev_reg        <= dev_next;
        sx_reg         <= sx_next;
        srem_reg       <= srem_next;
        sroot_reg      <= sroot_next;
        scnt_reg       <= scnt_next;
        out_reads_reg  <= out_reads_next;
        out_writes_reg <= out_writes_next;
        out_ratio_reg  <= out_ratio_next;
        out_mean_reg   <= out_mean_next;
        out_dev_reg    <= out_dev_next;
        out_status_reg <= out_status_next;
    end

    // A result with no writes carries no mean or deviation
    a_no_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_NO_WRITES
        |-> out_mean_reg == '0 && out_dev_reg == '0)
        else $error("no-write result carries a nonzero statistic");

    // Statistics never exceed the cap
    a_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_mean_reg <= OUT_CAP && out_dev_reg <= OUT_CAP)
        else $error("statistic above cap");

    // A new result comes only from the load step
    a_load_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_LOAD)
        else $error("result appeared outside the load step");

    // The totals are clear once a result has been loaded
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> read_reg == '0 && write_reg == '0 && !sat_reg)
        else $error("totals not cleared after result");

endmodule

// ----- rtl/core/io_trace_write_size_stats.sv -----
// Write-size statistics over a CSV I/O trace fed one character per cycle: push takes one
// character while full is low; lines are parsed in the front end and queued (4 lines) to the
// back end, which steps through idle, square and accumulate states for each closed line, so
// traces of very short lines raise full. End of trace (cmd 1) produces one result after up
// to three divides, seven shift-add multiplies and 31 square-root steps (fewer when a trace
// has no writes); the trace state then clears. The result waits in a register until popped
// while the front end keeps parsing.
// Top level; depends on iotws_pkg and the iotws modules.
module io_trace_write_size_stats import iotws_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [7:0]                char_byte,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_wdata,
    output logic                      empty,
    input  logic                      pop,
    output logic [OUT_COUNT_BITS-1:0] reads_seen,
    output logic [OUT_COUNT_BITS-1:0] writes_seen,
    output logic [RATIO_BITS-1:0]     write_ratio_q16,
    output logic [STAT_BITS-1:0]      mean_kib_q16,
    output logic [STAT_BITS-1:0]      deviation_kib_q16,
    output logic [1:0]                status
);

    logic q_push, q_full, q_pop, q_empty;
    rec_t q_in, q_out;

    // Parse characters into line records
    iotws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .char_byte (char_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (q_in)
    );

    // Decouple parsing from accumulation
    iotws_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (q_out),
        .empty    (q_empty)
    );

    // Accumulate and compute the result
    iotws_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_rec             (q_out),
        .q_pop             (q_pop),
        .empty             (empty),
        .pop               (pop),
        .reads_seen        (reads_seen),
        .writes_seen       (writes_seen),
        .write_ratio_q16   (write_ratio_q16),
        .mean_kib_q16      (mean_kib_q16),
        .deviation_kib_q16 (deviation_kib_q16),
        .status            (status)
    );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for io_trace_write_size_stats.
// Streams CSV trace characters, predicts each statistics result and checks it field by field.
// Depends on iotws_pkg and the block under test.
module testbench;
    import iotws_pkg::*;

    typedef struct packed {
        logic [31:0] reads;
        logic [31:0] writes;
        logic [16:0] ratio;
        logic [30:0] mean;
        logic [30:0] dev;
        logic [1:0]  st;
    } stats_t;

    localparam int CYCLE_LIMIT = 10000000;
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd;
    logic [7:0]  char_byte;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        empty;
    logic        pop;
    logic [31:0] reads_seen;
    logic [31:0] writes_seen;
    logic [16:0] write_ratio_q16;
    logic [30:0] mean_kib_q16;
    logic [30:0] deviation_kib_q16;
    logic [1:0]  status;

    io_trace_write_size_stats i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .char_byte(char_byte), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .empty(empty), .pop(pop), .reads_seen(reads_seen), .writes_seen(writes_seen),
        .write_ratio_q16(write_ratio_q16), .mean_kib_q16(mean_kib_q16),
        .deviation_kib_q16(deviation_kib_q16), .status(status)
    );

    // Predicted trace state
    logic [7:0]  sep_q;
    logic [2:0]  fld_num;
    logic [2:0]  type_len;
    logic        maybe_read;
    logic        maybe_write;
    logic [63:0] size_acc;
    logic        line_busy;
    logic [63:0] read_cnt;
    logic [63:0] write_cnt;
    logic [63:0] other_cnt;
    logic [63:0] sum_sz;
    logic [63:0] sum_sq;
    logic        sat_flag;

    stats_t stats_q[$];
    int     err_cnt = 0;
    int     result_cnt = 0;
    int     item_cnt = 0;
    int     cycle_cnt = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;

    always #4 clk = ~clk;

    function automatic void clear_trace_line();
        fld_num = 0;
        type_len = 0;
        maybe_read = 1'b1;
        maybe_write = 1'b1;
        size_acc = 0;
        line_busy = 1'b0;
    endfunction

    function automatic void clear_trace();
        clear_trace_line();
        read_cnt = 0;
        write_cnt = 0;
        other_cnt = 0;
        sum_sz = 0;
        sum_sq = 0;
        sat_flag = 1'b0;
    endfunction

    function automatic logic [63:0] add_capped(logic [63:0] a, logic [63:0] b,
                                               logic [64:0] cap);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > cap) begin
            sat_flag = 1'b1;
            return cap[63:0];
        end
        return s[63:0];
    endfunction

    function automatic void close_trace_line();
        logic rd;
        logic wr;
        rd = maybe_read && type_len == READ_LEN;
        wr = maybe_write && type_len == WRITE_LEN;
        if (rd) begin
            read_cnt = add_capped(read_cnt, 1, 65'hFFFF_FFFF);
        end
        else begin
            other_cnt = add_capped(other_cnt, 1, 65'hFFFF_FFFF);
            sum_sz = add_capped(sum_sz, size_acc, (65'd1 << 56) - 1);
            sum_sq = add_capped(sum_sq, size_acc * size_acc, (65'd1 << 64) - 1);
            if (wr)
                write_cnt = add_capped(write_cnt, 1, 65'hFFFF_FFFF);
        end
        clear_trace_line();
    endfunction

    function automatic logic [30:0] cap_stat(logic [255:0] q);
        if (q > 256'(1 << 30)) begin
            sat_flag = 1'b1;
            return OUT_CAP;
        end
        return q[30:0];
    endfunction

    // Build the statistics of the finished trace
    function automatic stats_t finish_trace();
        stats_t       s;
        logic [63:0]  tot;
        logic [255:0] w;
        logic [255:0] a;
        logic [255:0] b;
        logic [255:0] cc;
        logic [255:0] num;
        logic [255:0] q;
        logic [63:0]  x;
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [63:0]  ratio;
        if (line_busy)
            close_trace_line();
        tot = read_cnt + write_cnt;
        ratio = (tot != 0) ? ((write_cnt << FRAC_BITS) / tot) : 0;
        s.reads = read_cnt[31:0];
        s.writes = write_cnt[31:0];
        s.ratio = ratio[16:0];
        s.mean = 0;
        s.dev = 0;
        if (write_cnt != 0) begin
            w = 256'(write_cnt);
            s.mean = cap_stat((256'(sum_sz) << (FRAC_BITS - 10)) / w);
            a = 256'(sum_sq) * w * w;
            b = 256'(sum_sz) * 256'(sum_sz);
            cc = (b * w) << 1;
            num = a + b * 256'(other_cnt);
            if (num < cc) begin
                num = 0;
                sat_flag = 1'b1;
            end
            else begin
                num = num - cc;
            end
            q = (num << (2 * FRAC_BITS - 20)) / (w * w * w);
            if (q < (256'd1 << 62)) begin
                x = q[63:0];
                res = 0;
                for (int bit_i = 30; bit_i >= 0; bit_i--) begin
                    cand = res | (64'd1 << bit_i);
                    if (cand * cand <= x)
                        res = cand;
                end
                if (res > (64'd1 << 30)) begin
                    res = 64'd1 << 30;
                    sat_flag = 1'b1;
                end
                s.dev = res[30:0];
            end
            else begin
                s.dev = OUT_CAP;
                sat_flag = 1'b1;
            end
        end
        s.st = (write_cnt == 0) ? STATUS_NO_WRITES :
               (sat_flag ? STATUS_SATURATED : STATUS_OK);
        clear_trace();
        return s;
    endfunction

    // Advance the predicted parser by one trace character
    function automatic void parse_char(logic [7:0] c);
        string rd_word;
        string wr_word;
        logic [63:0] acc;
        rd_word = "Read";
        wr_word = "Write";
        if (c == CHAR_NEWLINE) begin
            if (fld_num == TYPE_FIELD) begin
                maybe_read = 1'b0;
                maybe_write = 1'b0;
            end
            close_trace_line();
            return;
        end
        line_busy = 1'b1;
        if (c == sep_q) begin
            if (fld_num < FIELD_LAST)
                fld_num++;
        end
        else if (fld_num == TYPE_FIELD) begin
            if (type_len >= 4 || c != rd_word[type_len])
                maybe_read = 1'b0;
            if (type_len >= 5 || c != wr_word[type_len])
                maybe_write = 1'b0;
            if (type_len < TYPE_CHARS_MAX)
                type_len++;
        end
        else if (fld_num == SIZE_FIELD && c >= CHAR_ZERO && c <= CHAR_NINE) begin
            acc = size_acc * 10 + 64'(c - CHAR_ZERO);
            if (acc > (64'd1 << SIZE_BITS) - 1) begin
                acc = (64'd1 << SIZE_BITS) - 1;
                sat_flag = 1'b1;
            end
            size_acc = acc;
        end
    endfunction

    // Send one transaction; push stays high after acceptance
    task automatic send_item(logic c_cmd, logic [7:0] c_byte);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        cmd <= c_cmd;
        char_byte <= c_byte;
        do @(posedge clk); while (full);
        item_cnt++;
        if (c_cmd == CMD_END)
            stats_q.push_back(finish_trace());
        else
            parse_char(c_byte);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(CMD_CHAR, s[i]);
    endtask

    task automatic end_trace();
        send_item(CMD_END, 8'($urandom));
    endtask

    // Drain results, then let the front end settle before a register write
    task automatic set_separator(logic [7:0] val);
        @(negedge clk);
        push <= 1'b0;
        wait (stats_q.size() == 0);
        repeat (50) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sep_q = val;
    endtask

    task automatic send_field_text(int n);
        for (int i = 0; i < n; i++)
            send_item(CMD_CHAR, 8'($urandom_range(8'h7a, 8'h61)));
    endtask

    // One line with random content; most are well formed
    task automatic send_line();
        int kind;
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(12, 1)) send_item(CMD_CHAR, 8'($urandom));
            send_item(CMD_CHAR, CHAR_NEWLINE);
            return;
        end
        for (int f = 0; f < 3; f++) begin
            send_field_text($urandom_range(2));
            send_item(CMD_CHAR, sep_q);
        end
        case ($urandom_range(5))
            0, 1: send_text("Read");
            2, 3: send_text("Write");
            4: send_text($urandom_range(1) ? "Wri" : "Writes");
            default: send_field_text($urandom_range(5));
        endcase
        if (kind < 12) begin
            send_item(CMD_CHAR, CHAR_NEWLINE);
            return;
        end
        send_item(CMD_CHAR, sep_q);
        send_field_text($urandom_range(1));
        send_item(CMD_CHAR, sep_q);
        repeat ((kind < 16) ? 9 : $urandom_range(7, 1))
            send_item(CMD_CHAR, 8'($urandom_range(CHAR_NINE, CHAR_ZERO)));
        if (kind > 90) begin
            repeat ($urandom_range(4, 1)) send_item(CMD_CHAR, sep_q);
            send_field_text(1);
        end
        if (kind < 95)
            send_item(CMD_CHAR, CHAR_NEWLINE);
    endtask

    task automatic test_basic_lines();
        end_trace();
        send_text("\n");
        end_trace();
        send_text("0,1,2,Write,4,4096\n0,1,2,Read,4,99\nx,y,z,Wri\n");
        end_trace();
    endtask

    task automatic test_line_edges();
        send_text("a,b,c,Write,d,99999999,e,f,g,h\n");
        send_item(CMD_CHAR, 8'h00);
        send_text(",,,Write,,7");
        end_trace();
    endtask

    task automatic test_separators();
        set_separator(8'h0a);
        send_text("a\nWrite\n");
        end_trace();
        set_separator(8'h00);
        send_item(CMD_CHAR, 8'hff);
        end_trace();
        set_separator(8'hff);
        send_item(CMD_CHAR, 8'h00);
        end_trace();
    endtask

    task automatic test_random_traces(int n_items);
        logic [7:0] seps[6];
        int start;
        seps = '{8'h2c, 8'h3b, 8'h09, 8'h7c, 8'h00, 8'hff};
        start = item_cnt;
        while (item_cnt - start < n_items) begin
            if ($urandom_range(3) == 0)
                set_separator(seps[$urandom_range(5)]);
            repeat ($urandom_range(4)) send_line();
            end_trace();
        end
    endtask

    // Receiver side: random back-pressure
    always @(negedge clk)
        pop <= ($urandom_range(99) >= rx_idle_pct);

    // Compare each popped transaction with the oldest prediction
    always @(posedge clk) begin
        stats_t want;
        if (rst_n && pop && !empty) begin
            if (stats_q.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end
            else begin
                want = stats_q.pop_front();
                result_cnt++;
                if (reads_seen !== want.reads) begin
                    $error("reads_seen exp %0d got %0d", want.reads, reads_seen);
                    err_cnt++;
                end
                if (writes_seen !== want.writes) begin
                    $error("writes_seen exp %0d got %0d", want.writes, writes_seen);
                    err_cnt++;
                end
                if (write_ratio_q16 !== want.ratio) begin
                    $error("write_ratio_q16 exp %0d got %0d", want.ratio, write_ratio_q16);
                    err_cnt++;
                end
                if (mean_kib_q16 !== want.mean) begin
                    $error("mean_kib_q16 exp %0d got %0d", want.mean, mean_kib_q16);
                    err_cnt++;
                end
                if (deviation_kib_q16 !== want.dev) begin
                    $error("deviation_kib_q16 exp %0d got %0d", want.dev, deviation_kib_q16);
                    err_cnt++;
                end
                if (status !== want.st) begin
                    $error("status exp %0d got %0d", want.st, status);
                    err_cnt++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        cmd = CMD_CHAR;
        char_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_wdata = 8'h00;
        pop = 1'b0;
        sep_q = SEP_RESET;
        clear_trace();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 78;
        test_basic_lines();
        test_line_edges();
        test_separators();
        set_separator(SEP_RESET);
        test_random_traces(380);
        tx_idle_pct = 78;
        rx_idle_pct = 10;
        test_random_traces(380);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traces(380);

        @(negedge clk);
        push <= 1'b0;
        wait (stats_q.size() == 0);
        repeat (1100) @(posedge clk);
        $display("Sent %0d trace characters and end marks; checked %0d statistics results",
                 item_cnt, result_cnt);
        $display("across several separators and three back-pressure mixes.");
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/iotws_pkg.sv
rtl/core/iotws_fifo.sv
rtl/core/iotws_front.sv
rtl/core/iotws_mul.sv
rtl/core/iotws_div.sv
rtl/core/iotws_back.sv
rtl/core/io_trace_write_size_stats.sv
dv/testbench.sv
